// File: design/lsrd_pkg.sv
// Shared constants and types for the LRU stack reuse-distance block.
// No dependencies; every other design file uses it by scoped name.
package lsrd_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int IDX_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = 64;
	localparam int CNT_W       = 32;
	localparam int HIST_BINS   = STACK_DEPTH + 1;

	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic             OP_ACCESS = 1'b0;
	localparam logic             OP_READ   = 1'b1;

	// histogram port request: one read and one write per cycle
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [CNT_W-1:0] wr_data;
	} hist_req_t;

endpackage

// File: design/lsrd_cell.sv
// One LRU stack cell: holds an address, compares it, shifts from its neighbor.
// Depends on lsrd_pkg.
module lsrd_cell (
	input  logic                      clk,
	input  logic [lsrd_pkg::ADDR_W-1:0] cmp_addr,
	input  logic                      active,
	input  logic                      shift_en,
	input  logic [lsrd_pkg::ADDR_W-1:0] prev_entry,
	output logic [lsrd_pkg::ADDR_W-1:0] entry,
	output logic                      match
);

	logic [lsrd_pkg::ADDR_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= prev_entry;
		end
	end

	assign entry = entry_q;
	assign match = active && (entry_q == cmp_addr);

endmodule

// File: design/lsrd_hist.sv
// Histogram store: one counter per distance, registered read, valid bit per bin.
// Depends on lsrd_pkg.
module lsrd_hist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lsrd_pkg::hist_req_t        req,
	output logic [lsrd_pkg::CNT_W-1:0] rd_count
);

	logic [lsrd_pkg::CNT_W-1:0]     mem [0:lsrd_pkg::HIST_BINS-1];
	logic [lsrd_pkg::HIST_BINS-1:0] bin_vld_q;
	logic [lsrd_pkg::CNT_W-1:0]     rd_data_q;
	logic                           rd_vld_q;

	// counters themselves have no reset; a bin never written reads as zero
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				bin_vld_q[req.wr_idx] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= bin_vld_q[req.rd_idx];
			end
		end
	end

	assign rd_count = rd_vld_q ? rd_data_q : '0;

endmodule

// File: design/lru_stack_reuse_distance.sv
// LRU stack reuse-distance histogram, top level.
// Result is valid once the request has passed the UPD and WB states.
// New requests enter only when idle or as the last retires (histogram RMW).
// Reset (arst_n low, async): stack empty, all histogram bins read as zero.
// Depends on lsrd_pkg, lsrd_cell, lsrd_hist.
module lru_stack_reuse_distance (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic [lsrd_pkg::ADDR_W-1:0] address,
	input  logic [lsrd_pkg::IDX_W-1:0]  bin_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lsrd_pkg::IDX_W-1:0]  distance,
	output logic                        hit,
	output logic [lsrd_pkg::CNT_W-1:0]  bin_count
);

	localparam int DEPTH = lsrd_pkg::STACK_DEPTH;
	localparam int IW    = lsrd_pkg::IDX_W;

	// sequencer: IDLE -> UPD (stack update, bin read) -> WB (bin write, result)
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// stage 1: captured request plus match vector of the stack
	logic                        op_s1;
	logic [lsrd_pkg::ADDR_W-1:0] addr_s1;
	logic [IW-1:0]               bin_s1;
	logic [DEPTH-1:0]            match_s1;

	// stage 2: resolved index into the histogram
	logic          op_s2;
	logic [IW-1:0] idx_s2;
	logic          hit_s2;
	logic          inrange_s2;

	logic [IW-1:0] fill_q;

	// output register
	logic                       out_valid_q;
	logic [IW-1:0]              distance_q;
	logic                       hit_q;
	logic [lsrd_pkg::CNT_W-1:0] bin_count_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        wb_done;
	logic [DEPTH-1:0]            match_now;
	logic [lsrd_pkg::ADDR_W-1:0] entries [0:DEPTH-1];
	logic [DEPTH-1:0]            shift_en;
	logic                        upd_access;
	logic                        hit_upd;
	logic [IW-1:0]               enc_pos;
	logic [IW-1:0]               idx_upd;
	logic                        inrange_upd;
	logic [lsrd_pkg::CNT_W-1:0]  rd_count;
	logic [lsrd_pkg::CNT_W-1:0]  cnt_new;
	lsrd_pkg::hist_req_t         hist_req;

	// ---------------- handshake ----------------
	assign out_free = !out_valid_q || !out_stall;
	assign wb_done  = (state_q == ST_WB) && out_free;
	// a new request enters while idle or while the previous one retires
	assign in_stall = !((state_q == ST_IDLE) || wb_done);
	assign in_acc   = in_valid && !in_stall;

	// ---------------- stack cells (newest at cell 0) ----------------
	assign upd_access = (state_q == ST_UPD) && (op_s1 == lsrd_pkg::OP_ACCESS);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [lsrd_pkg::ADDR_W-1:0] prev;
			if (gi == 0) begin : g_top
				assign prev = addr_s1;
			end else begin : g_rest
				assign prev = entries[gi-1];
			end
			// cells at or above the hit (all cells on a miss) move down one
			assign shift_en[gi] = upd_access && (IW'(gi) <= idx_upd);
			lsrd_cell u_cell (
				.clk       (clk),
				.cmp_addr  (address),
				.active    (IW'(gi) < fill_q),
				.shift_en  (shift_en[gi]),
				.prev_entry(prev),
				.entry     (entries[gi]),
				.match     (match_now[gi])
			);
		end
	endgenerate

	// one-hot match to position; number of newer entries equals cell index
	always_comb begin
		enc_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match_s1[i]) begin
				enc_pos = enc_pos | IW'(i);
			end
		end
	end

	assign hit_upd     = (op_s1 == lsrd_pkg::OP_ACCESS) && (match_s1 != '0);
	assign idx_upd     = (op_s1 == lsrd_pkg::OP_READ) ? bin_s1 :
	                     (hit_upd ? enc_pos : IW'(DEPTH));
	assign inrange_upd = (idx_upd <= IW'(DEPTH));

	// ---------------- histogram ----------------
	// saturating increment for an access; a read just passes the count
	assign cnt_new = (op_s2 == lsrd_pkg::OP_READ) ? rd_count :
	                 ((rd_count == lsrd_pkg::CNT_MAX) ? rd_count
	                                                  : rd_count + 1'b1);

	always_comb begin
		hist_req.rd_en   = (state_q == ST_UPD) && inrange_upd;
		hist_req.rd_idx  = idx_upd;
		hist_req.wr_en   = wb_done && (op_s2 == lsrd_pkg::OP_ACCESS);
		hist_req.wr_idx  = idx_s2;
		hist_req.wr_data = cnt_new;
	end

	lsrd_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hist_req),
		.rd_count(rd_count)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				if (wb_done) begin
					state_d = in_acc ? ST_UPD : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a miss grows the stack until it is full; a hit keeps the fill
			if (upd_access && !hit_upd && (fill_q != IW'(DEPTH))) begin
				fill_q <= fill_q + 1'b1;
			end
			if (wb_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= operation;
			addr_s1  <= address;
			bin_s1   <= bin_index;
			match_s1 <= match_now;
		end
		if (state_q == ST_UPD) begin
			op_s2      <= op_s1;
			idx_s2     <= idx_upd;
			hit_s2     <= hit_upd;
			inrange_s2 <= inrange_upd;
		end
		if (wb_done) begin
			distance_q  <= idx_s2;
			hit_q       <= hit_s2;
			bin_count_q <= inrange_s2 ? cnt_new : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign hit       = hit_q;
	assign bin_count = bin_count_q;

	// ---------------- assertions ----------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= IW'(DEPTH))
		else $error("stack fill beyond depth");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_now))
		else $error("address held in more than one cell");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_UPD))
		else $error("accepted request did not enter update");

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (distance < IW'(DEPTH)))
		else $error("hit reported with miss distance");

endmodule
